@@ src/ecsc_pkg.sv @@
// Shared types, constants and helper functions for the encoder setpoint control unit.
`default_nettype none

package ecsc_pkg;

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int COUNT_W    = 16;
    localparam int GLITCH_W   = 15;
    localparam int SETPOINT_W = 10;
    localparam int DAC_W      = 11;
    localparam int STEP_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Datapath widths
    localparam int STEP_MUL_W = 8;                        // signed step constant
    localparam int PROD_W     = COUNT_W + STEP_MUL_W;     // delta * step
    localparam int SUM_W      = PROD_W + 1;               // setpoint - product
    localparam int SCALED_W   = SETPOINT_W + 16;          // mA in Q16
    localparam int GAIN_W     = 18;
    localparam int DAC_PROD_W = SCALED_W + GAIN_W;
    localparam int MV_W       = DAC_PROD_W - 32;

    // Conversion constants in Q16
    localparam logic [SCALED_W-1:0] OFFSET_Q16 = SCALED_W'(89678);
    localparam logic [GAIN_W-1:0]   GAIN_Q16   = GAIN_W'(131549);

    // Event codes
    localparam logic [ACTION_W-1:0] ACT_SAMPLE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STEP    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CHANNEL = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_POWER   = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SETPOINT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_LIMIT    = 2'd2;

    // Reset values
    localparam logic [GLITCH_W-1:0]   RST_GLITCH_LIMIT = 15'd50;
    localparam logic [SETPOINT_W-1:0] RST_MAX_SETPOINT = 10'd600;
    localparam logic [DAC_W-1:0]      RST_DAC_LIMIT    = 11'd1400;

    // Step index codes
    localparam logic [STEP_W-1:0] STEP_1MA   = 2'd0;
    localparam logic [STEP_W-1:0] STEP_10MA  = 2'd1;
    localparam logic [STEP_W-1:0] STEP_100MA = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_CLAMP,
        ST_CONVERT,
        ST_LIMIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic eval;
        logic scale;
        logic clamp;
        logic convert;
        logic limit;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic adjust;
    } sts_t;

    function automatic logic signed [STEP_MUL_W-1:0] step_ma(input logic [STEP_W-1:0] idx);
        logic signed [STEP_MUL_W-1:0] val;
        unique case (idx)
            STEP_1MA:   val = 8'sd1;
            STEP_10MA:  val = 8'sd10;
            STEP_100MA: val = 8'sd100;
            default:    val = 8'sd1;
        endcase
        return val;
    endfunction

    function automatic logic [STEP_W-1:0] step_advance(input logic [STEP_W-1:0] idx);
        logic [STEP_W-1:0] val;
        unique case (idx)
            STEP_1MA:   val = STEP_10MA;
            STEP_10MA:  val = STEP_100MA;
            default:    val = STEP_1MA;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

@@ src/ecsc_ctrl.sv @@
// Sequencing state machine and output valid flag for the setpoint control unit.
`default_nettype none

module ecsc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire ecsc_pkg::sts_t sts,
    output ecsc_pkg::cmd_t     cmd
);
    import ecsc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sts.adjust ? ST_SCALE : ST_EMIT;
                end
            end
            ST_SCALE:   state_next = ST_CLAMP;
            ST_CLAMP:   state_next = ST_CONVERT;
            ST_CONVERT: state_next = ST_LIMIT;
            ST_LIMIT:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.eval    = accept;
        cmd.scale   = (state_reg == ST_SCALE);
        cmd.clamp   = (state_reg == ST_CLAMP);
        cmd.convert = (state_reg == ST_CONVERT);
        cmd.limit   = (state_reg == ST_LIMIT);
        cmd.emit    = (state_reg == ST_EMIT) && out_free;
    end

    always_comb
    begin
        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("output valid rose outside the emit state");

    a_adjust_path: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sts.adjust) |=> (state_reg == ST_SCALE))
        else $error("adjusting sample did not enter the scale step");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_valid_reg && out_stall) |=> (state_reg == ST_EMIT))
        else $error("emit left while the previous result was stalled");

endmodule

`default_nettype wire

@@ src/ecsc_dp.sv @@
// Datapath: configuration, delta and glitch check, setpoint update and DAC conversion.
`default_nettype none

module ecsc_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [ecsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ecsc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [ecsc_pkg::ACTION_W-1:0]       action,
    input  wire logic [ecsc_pkg::COUNT_W-1:0]        encoder_count,
    input  wire ecsc_pkg::cmd_t                      cmd,
    output ecsc_pkg::sts_t                           sts,
    output logic [ecsc_pkg::SETPOINT_W-1:0]          setpoint_ma,
    output logic [ecsc_pkg::DAC_W-1:0]               dac_mv,
    output logic [ecsc_pkg::STEP_W-1:0]              step_select,
    output logic                                     channel_select,
    output logic                                     power_enable,
    output logic                                     glitch_seen
);
    import ecsc_pkg::*;

    // Configuration
    logic [GLITCH_W-1:0]   glitch_limit_reg;
    logic [SETPOINT_W-1:0] max_setpoint_reg;
    logic [DAC_W-1:0]      dac_limit_reg;

    // Architectural state
    logic [COUNT_W-1:0]    prev_count_reg, prev_count_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  channel_reg, channel_next;
    logic                  enable_reg, enable_next;
    logic [SETPOINT_W-1:0] setpoint_reg;
    logic [DAC_W-1:0]      dac_reg;
    logic                  glitch_reg, glitch_next;

    // Working registers
    logic signed [COUNT_W-1:0] delta_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [DAC_PROD_W-1:0]     dac_prod_reg, dac_prod_next;
    logic                      dac_zero_reg;

    // Output registers
    logic [SETPOINT_W-1:0] out_setpoint_reg;
    logic [DAC_W-1:0]      out_dac_reg;
    logic [STEP_W-1:0]     out_step_reg;
    logic                  out_channel_reg;
    logic                  out_enable_reg;
    logic                  out_glitch_reg;

    logic signed [COUNT_W-1:0] delta;
    logic [COUNT_W-1:0]        mag;
    logic                      is_sample;
    logic                      moved;
    logic                      over_limit;
    logic signed [SUM_W-1:0]   sum;
    logic [SETPOINT_W-1:0]     setpoint_next;
    logic [SCALED_W-1:0]       scaled;
    logic                      dac_zero_next;
    logic [MV_W-1:0]           mv;
    logic [DAC_W-1:0]          dac_next;

    // Event evaluation on the accepted beat
    always_comb
    begin
        delta      = signed'(encoder_count - prev_count_reg);
        mag        = delta[COUNT_W-1] ? (COUNT_W'(0) - COUNT_W'(delta)) : COUNT_W'(delta);
        is_sample  = (action == ACT_SAMPLE);
        moved      = is_sample && (delta != '0);
        over_limit = (mag > {1'b0, glitch_limit_reg});
        sts.adjust = moved && !over_limit && channel_reg;

        prev_count_next = moved ? encoder_count : prev_count_reg;
        glitch_next     = moved && over_limit;
        step_next       = (action == ACT_STEP) ? step_advance(step_reg) : step_reg;
        channel_next    = (action == ACT_CHANNEL) ? !channel_reg : channel_reg;
        enable_next     = (action == ACT_POWER) ? !enable_reg : enable_reg;
    end

    // Setpoint: scale then clamp
    assign prod_next = PROD_W'(delta_reg) * PROD_W'(step_ma(step_reg));

    always_comb
    begin
        sum = $signed({{(SUM_W-SETPOINT_W){1'b0}}, setpoint_reg}) - SUM_W'(prod_reg);
        priority if (sum < 0)
        begin
            setpoint_next = '0;
        end
        else if (sum > $signed({{(SUM_W-SETPOINT_W){1'b0}}, max_setpoint_reg}))
        begin
            setpoint_next = max_setpoint_reg;
        end
        else
        begin
            setpoint_next = sum[SETPOINT_W-1:0];
        end
    end

    // DAC conversion: offset removal and gain in Q16, then limit
    assign scaled        = {setpoint_reg, 16'd0};
    assign dac_zero_next = (scaled <= OFFSET_Q16);
    assign dac_prod_next = DAC_PROD_W'(scaled - OFFSET_Q16) * DAC_PROD_W'(GAIN_Q16);
    assign mv            = dac_prod_reg[DAC_PROD_W-1:32];

    always_comb
    begin
        priority if (dac_zero_reg)
        begin
            dac_next = '0;
        end
        else if (mv > {1'b0, dac_limit_reg})
        begin
            dac_next = dac_limit_reg;
        end
        else
        begin
            dac_next = mv[DAC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glitch_limit_reg <= RST_GLITCH_LIMIT;
            max_setpoint_reg <= RST_MAX_SETPOINT;
            dac_limit_reg    <= RST_DAC_LIMIT;
            prev_count_reg   <= '0;
            step_reg         <= STEP_10MA;
            channel_reg      <= 1'b0;
            enable_reg       <= 1'b0;
            setpoint_reg     <= '0;
            dac_reg          <= '0;
            glitch_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_GLITCH_LIMIT: glitch_limit_reg <= cfg_data[GLITCH_W-1:0];
                    CFG_MAX_SETPOINT: max_setpoint_reg <= cfg_data[SETPOINT_W-1:0];
                    CFG_DAC_LIMIT:    dac_limit_reg    <= cfg_data[DAC_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.eval)
            begin
                prev_count_reg <= prev_count_next;
                step_reg       <= step_next;
                channel_reg    <= channel_next;
                enable_reg     <= enable_next;
                glitch_reg     <= glitch_next;
            end
            if (cmd.clamp)
            begin
                setpoint_reg <= setpoint_next;
            end
            if (cmd.limit)
            begin
                dac_reg <= dac_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            delta_reg <= delta;
        end
        if (cmd.scale)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.convert)
        begin
            dac_prod_reg <= dac_prod_next;
            dac_zero_reg <= dac_zero_next;
        end
        if (cmd.emit)
        begin
            out_setpoint_reg <= setpoint_reg;
            out_dac_reg      <= dac_reg;
            out_step_reg     <= step_reg;
            out_channel_reg  <= channel_reg;
            out_enable_reg   <= enable_reg;
            out_glitch_reg   <= glitch_reg;
        end
    end

    assign setpoint_ma    = out_setpoint_reg;
    assign dac_mv         = out_dac_reg;
    assign step_select    = out_step_reg;
    assign channel_select = out_channel_reg;
    assign power_enable   = out_enable_reg;
    assign glitch_seen    = out_glitch_reg;

    a_setpoint_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.clamp) |-> (setpoint_reg <= $past(max_setpoint_reg)))
        else $error("setpoint above its clamp after an adjustment");

    a_dac_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.limit) |-> (dac_reg <= $past(dac_limit_reg)))
        else $error("DAC target above its limit after a conversion");

    a_step_code: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_1MA) || (step_reg == STEP_10MA) || (step_reg == STEP_100MA))
        else $error("step index left its three codes");

endmodule

`default_nettype wire

@@ src/encoder_current_setpoint_control_unit.sv @@
// Top level of the encoder setpoint control unit: controller plus datapath.
`default_nettype none

// Sequence: an encoder sample that adjusts the setpoint goes through scale, clamp, convert,
//   limit and emit after acceptance; any other event goes straight to emit.
// Events: a new event is accepted only once the sequencer has returned to idle, since it
//   walks the datapath through the multiply chain one step at a time.
// Reset: rst_n clears, asynchronously, the sequencer, the output valid flag and the event
//   state; configuration registers return to their defaults (50, 600 mA, 1400 mV).
module encoder_current_setpoint_control_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_write,
    input  wire logic [ecsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ecsc_pkg::CFG_DATA_W-1:0] cfg_data,
    // event channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [ecsc_pkg::ACTION_W-1:0]   action,
    input  wire logic [ecsc_pkg::COUNT_W-1:0]    encoder_count,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [ecsc_pkg::SETPOINT_W-1:0]      setpoint_ma,
    output logic [ecsc_pkg::DAC_W-1:0]           dac_mv,
    output logic [ecsc_pkg::STEP_W-1:0]          step_select,
    output logic                                 channel_select,
    output logic                                 power_enable,
    output logic                                 glitch_seen
);
    import ecsc_pkg::*;

    // Commands run from the sequencer into the datapath; the datapath reports back
    // whether the accepted beat needs the full setpoint adjustment.
    cmd_t cmd;
    sts_t sts;

    // Sequencer: takes one event beat at a time, steps the datapath through the
    // multiply chain, and holds the finished result in the output register until
    // the sink takes it. A new beat is accepted while a result still waits.
    ecsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: delta and glitch check on the accepted beat, key handling, setpoint
    // scale and clamp, then Q16 conversion to the DAC target and its limit.
    ecsc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .action         (action),
        .encoder_count  (encoder_count),
        .cmd            (cmd),
        .sts            (sts),
        .setpoint_ma    (setpoint_ma),
        .dac_mv         (dac_mv),
        .step_select    (step_select),
        .channel_select (channel_select),
        .power_enable   (power_enable),
        .glitch_seen    (glitch_seen)
    );

endmodule

`default_nettype wire
